// ===== design/trtd_pkg.sv =====
package trtd_pkg;

  // Sequencer modes, also the ts_state code of a result word
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_CLOSING  = 3'd1,
    MODE_WAIT_R2D = 3'd2,
    MODE_START_INV = 3'd3,
    MODE_BUZZER   = 3'd4,
    MODE_DRIVING  = 3'd5,
    MODE_ERROR    = 3'd6
  } mode_t;

  // Contactor status codes
  localparam logic [1:0] CON_OTHER  = 2'd0;
  localparam logic [1:0] CON_READY  = 2'd1;
  localparam logic [1:0] CON_ACTIVE = 2'd2;
  localparam logic [1:0] CON_ERROR  = 2'd3;

  // Inverter status codes
  localparam logic [1:0] INV_OTHER   = 2'd0;
  localparam logic [1:0] INV_DRIVE   = 2'd1;
  localparam logic [1:0] INV_ERROR   = 2'd2;
  localparam logic [1:0] INV_UNKNOWN = 2'd3;

  // Contactor commands
  localparam logic [1:0] CCMD_NONE  = 2'd0;
  localparam logic [1:0] CCMD_CLOSE = 2'd1;
  localparam logic [1:0] CCMD_OPEN  = 2'd2;

  // Inverter commands
  localparam logic [1:0] ICMD_NONE  = 2'd0;
  localparam logic [1:0] ICMD_START = 2'd1;
  localparam logic [1:0] ICMD_STOP  = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_CLOSE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_BUZZER_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_TORQUE    = 2'd2;

  // Register reset values
  localparam logic [15:0] CLOSE_TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] BUZZER_LENGTH_RESET = 16'd2000;
  localparam logic [14:0] MAX_TORQUE_RESET    = 15'd0;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               loop_closed;
    logic               tsas_pressed;
    logic               start_pressed;
    logic               brakes_on;
    logic [1:0]         contactor_status;
    logic [1:0]         inverter_status;
    logic signed [15:0] drive_fraction;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  ts_state;
    logic [1:0]  contactor_cmd;
    logic [1:0]  inverter_cmd;
    logic        buzzer_level;
    logic        r2d_led;
    logic        torque_valid;
    logic [14:0] torque_request;
  } out_word_t;

endpackage

// ===== design/tractive_ready_to_drive_sequencer.sv =====
// Accepted words go to the input register; results are written to the result register.
// Throughput: one word per cycle while out_stall is low; a single pass of step logic
// sits between input and result registers; mode and timer registers update with it.
// Reset (rst, synchronous, active high): mode idle, timers and buzzer cleared,
// registers back to 1000 ms close timeout, 2000 ms buzzer, zero max torque.
module tractive_ready_to_drive_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  trtd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output trtd_pkg::out_word_t out_word,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // Configuration registers
  logic [15:0] close_timeout_ms;
  logic [15:0] buzzer_length_ms;
  logic [14:0] max_torque;

  // Input register
  logic               hold_valid;
  trtd_pkg::in_word_t hold_word;

  // Sequencer state
  trtd_pkg::mode_t mode, mode_pre, mode_next;
  logic [31:0]     close_start_time, close_start_time_next;
  logic [31:0]     buzzer_start_time, buzzer_start_time_next;
  logic            buzzer_held, buzzer_held_next;

  logic        advance;
  logic        in_accept;
  logic        lp;
  logic        con_fault;
  logic        inv_bad;
  logic [31:0] close_limit;
  logic [31:0] buzzer_limit;
  logic        close_due;
  logic        buzzer_due;
  logic [1:0]  ccmd;
  logic [1:0]  icmd;
  logic [14:0] frac_pos;
  logic [29:0] product;
  logic [14:0] torque_raw;
  logic [14:0] torque_clamped;
  logic        driving;

  // Handshake: the held word moves on when the result register is free
  assign advance   = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_word <= in_word;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      close_timeout_ms <= trtd_pkg::CLOSE_TIMEOUT_RESET;
      buzzer_length_ms <= trtd_pkg::BUZZER_LENGTH_RESET;
      max_torque       <= trtd_pkg::MAX_TORQUE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        trtd_pkg::CFG_CLOSE_TIMEOUT: close_timeout_ms <= cfg_data;
        trtd_pkg::CFG_BUZZER_LENGTH: buzzer_length_ms <= cfg_data;
        trtd_pkg::CFG_MAX_TORQUE:    max_torque       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Status decode and deadlines (wrapped 32-bit sum, unsigned compare)
  assign lp           = hold_word.loop_closed;
  assign con_fault    = hold_word.contactor_status == trtd_pkg::CON_ERROR;
  assign inv_bad      = (hold_word.inverter_status == trtd_pkg::INV_ERROR) ||
                        (hold_word.inverter_status == trtd_pkg::INV_UNKNOWN);
  assign close_limit  = close_start_time + 32'(close_timeout_ms);
  assign buzzer_limit = buzzer_start_time + 32'(buzzer_length_ms);
  assign close_due    = hold_word.now_ms > close_limit;
  assign buzzer_due   = hold_word.now_ms > buzzer_limit;

  // Safety pre-checks: contactor fault forces error, open loop falls to idle
  always_comb begin
    mode_pre = mode;
    if (con_fault) begin
      mode_pre = trtd_pkg::MODE_ERROR;
    end
    if (!lp && mode_pre != trtd_pkg::MODE_ERROR) begin
      mode_pre = trtd_pkg::MODE_IDLE;
    end
  end

  // Next state and timers
  always_comb begin
    mode_next              = mode_pre;
    close_start_time_next  = close_start_time;
    buzzer_start_time_next = buzzer_start_time;
    buzzer_held_next       = buzzer_held;
    case (mode_pre)
      trtd_pkg::MODE_IDLE: begin
        if (hold_word.contactor_status == trtd_pkg::CON_READY && lp &&
            hold_word.tsas_pressed) begin
          mode_next             = trtd_pkg::MODE_CLOSING;
          close_start_time_next = hold_word.now_ms;
        end
      end
      trtd_pkg::MODE_CLOSING: begin
        if (hold_word.contactor_status == trtd_pkg::CON_ACTIVE && lp) begin
          mode_next = trtd_pkg::MODE_WAIT_R2D;
        end else if (!lp) begin
          mode_next = trtd_pkg::MODE_IDLE;
        end else if (close_due) begin
          mode_next = trtd_pkg::MODE_ERROR;
        end
      end
      trtd_pkg::MODE_WAIT_R2D: begin
        if (hold_word.contactor_status == trtd_pkg::CON_ACTIVE && lp &&
            hold_word.brakes_on && hold_word.start_pressed) begin
          mode_next = trtd_pkg::MODE_START_INV;
        end
      end
      trtd_pkg::MODE_START_INV: begin
        if (hold_word.inverter_status == trtd_pkg::INV_DRIVE) begin
          buzzer_held_next       = 1'b1;
          mode_next              = trtd_pkg::MODE_BUZZER;
          buzzer_start_time_next = hold_word.now_ms;
        end else if (inv_bad) begin
          mode_next = trtd_pkg::MODE_ERROR;
        end
      end
      trtd_pkg::MODE_BUZZER: begin
        if (buzzer_due) begin
          buzzer_held_next = 1'b0;
          mode_next        = trtd_pkg::MODE_DRIVING;
        end
      end
      trtd_pkg::MODE_DRIVING: begin
        if (inv_bad) begin
          mode_next = trtd_pkg::MODE_ERROR;
        end
      end
      default: ;
    endcase
  end

  // Commands for this tick; inverter stop from the pre-checks on loop or contactor fault while it reports drive
  always_comb begin
    icmd = (hold_word.inverter_status == trtd_pkg::INV_DRIVE && (!lp || con_fault)) ?
           trtd_pkg::ICMD_STOP : trtd_pkg::ICMD_NONE;
    ccmd = (con_fault || !lp) ? trtd_pkg::CCMD_OPEN : trtd_pkg::CCMD_NONE;
    case (mode_pre)
      trtd_pkg::MODE_IDLE: begin
        if (hold_word.contactor_status == trtd_pkg::CON_READY && lp &&
            hold_word.tsas_pressed) begin
          ccmd = trtd_pkg::CCMD_CLOSE;
        end
      end
      trtd_pkg::MODE_CLOSING: begin
        if (!(hold_word.contactor_status == trtd_pkg::CON_ACTIVE && lp) &&
            (!lp || close_due)) begin
          ccmd = trtd_pkg::CCMD_OPEN;
        end
      end
      trtd_pkg::MODE_WAIT_R2D: begin
        if (hold_word.contactor_status == trtd_pkg::CON_ACTIVE && lp &&
            hold_word.brakes_on && hold_word.start_pressed) begin
          icmd = trtd_pkg::ICMD_START;
        end
      end
      trtd_pkg::MODE_ERROR: begin
        icmd = trtd_pkg::ICMD_STOP;
      end
      default: ;
    endcase
  end

  // Torque: positive fraction times max, Q15 truncated, clamped to max
  assign frac_pos       = hold_word.drive_fraction[15] ? 15'd0 : hold_word.drive_fraction[14:0];
  assign product        = 30'(frac_pos) * 30'(max_torque);
  assign torque_raw     = product[29:15];
  assign torque_clamped = (torque_raw > max_torque) ? max_torque : torque_raw;
  assign driving        = mode_next == trtd_pkg::MODE_DRIVING;

  // State update, one step per word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= trtd_pkg::MODE_IDLE;
      close_start_time  <= 32'd0;
      buzzer_start_time <= 32'd0;
      buzzer_held       <= 1'b0;
    end else if (advance) begin
      mode              <= mode_next;
      close_start_time  <= close_start_time_next;
      buzzer_start_time <= buzzer_start_time_next;
      buzzer_held       <= buzzer_held_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word.ts_state       <= mode_next;
      out_word.contactor_cmd  <= ccmd;
      out_word.inverter_cmd   <= icmd;
      out_word.buzzer_level   <= buzzer_held_next;
      out_word.r2d_led        <= driving;
      out_word.torque_valid   <= driving;
      out_word.torque_request <= driving ? torque_clamped : 15'd0;
    end
  end

  // Error is sticky until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == trtd_pkg::MODE_ERROR |=> mode == trtd_pkg::MODE_ERROR)
    else $error("left error mode without reset");

  // Mode only moves when a word is processed
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(mode))
    else $error("mode changed without a word");

  // No torque outside driving
  a_torque_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.torque_valid |-> out_word.torque_request == 15'd0)
    else $error("torque request without valid");

  // Torque never exceeds the clamp
  a_torque_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.torque_request <= max_torque)
    else $error("torque request above max");

  // Lamp follows the driving state of the result
  a_led_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_word.r2d_led == (out_word.ts_state == trtd_pkg::MODE_DRIVING))
    else $error("lamp and state disagree");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import trtd_pkg::*;

  // Index with no register behind it, writes there must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tractive_ready_to_drive_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sequencer shadow state and register copies
  mode_t       m_mode = MODE_IDLE;
  logic [31:0] m_close_t0 = '0;
  logic [31:0] m_buzz_t0 = '0;
  logic        m_buzz_held = 1'b0;
  logic [15:0] r_close_timeout = CLOSE_TIMEOUT_RESET;
  logic [15:0] r_buzz_len = BUZZER_LENGTH_RESET;
  logic [14:0] r_max_torque = MAX_TORQUE_RESET;

  out_word_t   pending_results[$];
  int          words_sent = 0;
  int          results_seen = 0;
  int          err_count = 0;
  int          drive_entries = 0;
  logic [31:0] clock_ms = '0;
  bit          idle_on = 1'b1;
  bit          long_hold = 1'b0;

  // Deadline compares against a wrapped 32-bit sum
  function automatic bit deadline_hit(logic [31:0] now, logic [31:0] t0, logic [15:0] len);
    logic [31:0] lim;
    lim = t0 + {16'd0, len};
    return now > lim;
  endfunction

  // One control tick of the sequencer: updates the shadow state, returns the result word
  function automatic out_word_t predict_result(in_word_t w);
    out_word_t   r;
    logic [1:0]  ccmd;
    logic [1:0]  icmd;
    logic        inv_bad;
    logic [31:0] frac_pos;
    logic [31:0] trq;
    ccmd = CCMD_NONE;
    icmd = ICMD_NONE;
    inv_bad = (w.inverter_status == INV_ERROR) || (w.inverter_status == INV_UNKNOWN);

    // safety pre-checks
    if (w.inverter_status == INV_DRIVE && (!w.loop_closed || w.contactor_status == CON_ERROR))
      icmd = ICMD_STOP;
    if (w.contactor_status == CON_ERROR) begin
      ccmd = CCMD_OPEN;
      m_mode = MODE_ERROR;
    end
    if (!w.loop_closed) begin
      ccmd = CCMD_OPEN;
      if (m_mode != MODE_ERROR) m_mode = MODE_IDLE;
    end

    case (m_mode)
      MODE_IDLE: begin
        if (w.contactor_status == CON_READY && w.loop_closed && w.tsas_pressed) begin
          ccmd = CCMD_CLOSE;
          m_mode = MODE_CLOSING;
          m_close_t0 = w.now_ms;
        end
      end
      MODE_CLOSING: begin
        if (w.contactor_status == CON_ACTIVE && w.loop_closed) begin
          m_mode = MODE_WAIT_R2D;
        end else if (!w.loop_closed) begin
          ccmd = CCMD_OPEN;
          m_mode = MODE_IDLE;
        end else if (deadline_hit(w.now_ms, m_close_t0, r_close_timeout)) begin
          ccmd = CCMD_OPEN;
          m_mode = MODE_ERROR;
        end
      end
      MODE_WAIT_R2D: begin
        if (w.contactor_status == CON_ACTIVE && w.loop_closed && w.brakes_on &&
            w.start_pressed) begin
          icmd = ICMD_START;
          m_mode = MODE_START_INV;
        end
      end
      MODE_START_INV: begin
        if (w.inverter_status == INV_DRIVE) begin
          m_buzz_held = 1'b1;
          m_mode = MODE_BUZZER;
          m_buzz_t0 = w.now_ms;
        end else if (inv_bad) begin
          m_mode = MODE_ERROR;
        end
      end
      MODE_BUZZER: begin
        if (deadline_hit(w.now_ms, m_buzz_t0, r_buzz_len)) begin
          m_buzz_held = 1'b0;
          m_mode = MODE_DRIVING;
          drive_entries++;
        end
      end
      MODE_DRIVING: begin
        if (inv_bad) m_mode = MODE_ERROR;
      end
      MODE_ERROR: icmd = ICMD_STOP;
      default: ;
    endcase

    r = '0;
    // torque = fraction * max, truncated, negative throttle gives zero
    if (m_mode == MODE_DRIVING) begin
      frac_pos = (w.drive_fraction > 0) ? {16'd0, w.drive_fraction} : 32'd0;
      trq = (frac_pos * {17'd0, r_max_torque}) >> 15;
      if (trq > {17'd0, r_max_torque}) trq = {17'd0, r_max_torque};
      r.torque_valid = 1'b1;
      r.torque_request = trq[14:0];
    end
    r.ts_state = m_mode;
    r.contactor_cmd = ccmd;
    r.inverter_cmd = icmd;
    r.buzzer_level = m_buzz_held;
    r.r2d_led = (m_mode == MODE_DRIVING);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected, ts_state %0d", out_word.ts_state);
        err_count++;
      end else begin
        exp_w = pending_results.pop_front();
        check_field("ts_state", 32'(exp_w.ts_state), 32'(out_word.ts_state));
        check_field("contactor_cmd", 32'(exp_w.contactor_cmd), 32'(out_word.contactor_cmd));
        check_field("inverter_cmd", 32'(exp_w.inverter_cmd), 32'(out_word.inverter_cmd));
        check_field("buzzer_level", 32'(exp_w.buzzer_level), 32'(out_word.buzzer_level));
        check_field("r2d_led", 32'(exp_w.r2d_led), 32'(out_word.r2d_led));
        check_field("torque_valid", 32'(exp_w.torque_valid), 32'(out_word.torque_valid));
        check_field("torque_request", 32'(exp_w.torque_request),
                    32'(out_word.torque_request));
      end
    end
  end

  // Receiver stall: short random bursts, or one long hold-off on request
  initial begin : rx_stall
    int held;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one word, optionally after a gap; predict once it is taken
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(w));
    words_sent++;
  endtask

  // Let every outstanding result come back, then let the block drain
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] close_ms, logic [15:0] buzz_ms, logic [14:0] torque);
    logic msb;
    msb = 1'($urandom_range(0, 1));
    put_reg(CFG_CLOSE_TIMEOUT, close_ms);
    put_reg(CFG_BUZZER_LENGTH, buzz_ms);
    put_reg(CFG_MAX_TORQUE, {msb, torque});
    put_reg(CFG_UNUSED, 16'($urandom));
    cfg_write <= 1'b0;
    r_close_timeout = close_ms;
    r_buzz_len = buzz_ms;
    r_max_torque = torque;
  endtask

  task automatic tick(logic [31:0] dt, logic lp, logic tsas, logic start_btn, logic brakes,
                      logic [1:0] con, logic [1:0] inv, logic signed [15:0] frac);
    in_word_t w;
    clock_ms = clock_ms + dt;
    w.now_ms = clock_ms;
    w.loop_closed = lp;
    w.tsas_pressed = tsas;
    w.start_pressed = start_btn;
    w.brakes_on = brakes;
    w.contactor_status = con;
    w.inverter_status = inv;
    w.drive_fraction = frac;
    send_word(w);
  endtask

  // From idle up to the buzzer phase, loop closed throughout
  task automatic go_buzzer();
    tick(7, 1, 1, 0, 0, CON_READY, INV_OTHER, 16'sd0);
    tick(2, 1, 0, 0, 0, CON_ACTIVE, INV_OTHER, 16'sd0);
    tick(2, 1, 0, 1, 1, CON_ACTIVE, INV_UNKNOWN, 16'sd0);
    tick(2, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd0);
  endtask

  // Random tick steered along the sequence, never into the sticky error state
  task automatic random_tick();
    in_word_t    w;
    mode_t       eff;
    logic [31:0] dt;
    w.loop_closed = ($urandom_range(0, 99) < 96);
    w.tsas_pressed = 1'($urandom_range(0, 1));
    w.start_pressed = 1'($urandom_range(0, 1));
    w.brakes_on = 1'($urandom_range(0, 1));
    w.contactor_status = 2'($urandom_range(0, 2));
    w.inverter_status = 2'($urandom_range(0, 3));
    w.drive_fraction = 16'($urandom);
    case ($urandom_range(0, 19))
      0:       dt = $urandom;
      1, 2, 3: dt = $urandom_range(0, 3000);
      default: dt = $urandom_range(0, 40);
    endcase
    clock_ms = clock_ms + dt;
    eff = w.loop_closed ? m_mode : MODE_IDLE;
    case (eff)
      MODE_IDLE: begin
        if ($urandom_range(0, 1)) begin
          w.tsas_pressed = 1'b1;
          w.contactor_status = CON_READY;
        end
      end
      MODE_CLOSING: begin
        if ($urandom_range(0, 4) == 0) clock_ms = m_close_t0 + 32'(r_close_timeout);
        if ($urandom_range(0, 2) == 0) w.contactor_status = CON_ACTIVE;
        // a missed close deadline is fatal, so contactors report in time
        if (deadline_hit(clock_ms, m_close_t0, r_close_timeout))
          w.contactor_status = CON_ACTIVE;
      end
      MODE_WAIT_R2D: begin
        if ($urandom_range(0, 4) != 0) w.contactor_status = CON_ACTIVE;
        if ($urandom_range(0, 2) != 0) begin
          w.brakes_on = 1'b1;
          w.start_pressed = 1'b1;
        end
      end
      MODE_START_INV: w.inverter_status = $urandom_range(0, 1) ? INV_DRIVE : INV_OTHER;
      MODE_BUZZER: begin
        // land on or just past the buzzer deadline
        if ($urandom_range(0, 2) == 0)
          clock_ms = m_buzz_t0 + 32'(r_buzz_len) + $urandom_range(0, 1);
      end
      MODE_DRIVING: begin
        if (w.inverter_status[1])
          w.inverter_status = $urandom_range(0, 1) ? INV_DRIVE : INV_OTHER;
        case ($urandom_range(0, 9))
          0:       w.drive_fraction = 16'sh7FFF;
          1:       w.drive_fraction = 16'sh8000;
          2:       w.drive_fraction = 16'sd0;
          default: ;
        endcase
      end
      default: ;
    endcase
    w.now_ms = clock_ms;
    send_word(w);
  endtask

  task automatic run_random(int n);
    repeat (n) random_tick();
  endtask

  // Whole sequence with reset register values, both deadlines on the boundary
  task automatic test_reset_values();
    tick(0, 0, 0, 0, 0, CON_OTHER, INV_OTHER, 16'sd0);
    tick(5, 1, 1, 0, 0, CON_READY, INV_OTHER, 16'sd0);
    tick(32'(CLOSE_TIMEOUT_RESET), 1, 0, 0, 0, CON_OTHER, INV_OTHER, 16'sd0);
    tick(0, 1, 0, 0, 0, CON_ACTIVE, INV_OTHER, 16'sd0);
    tick(3, 1, 0, 1, 1, CON_ACTIVE, INV_OTHER, 16'sd0);
    tick(3, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd0);
    tick(32'(BUZZER_LENGTH_RESET), 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd0);
    tick(1, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sh7FFF);
    tick(1, 0, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd0);
    wait_quiet();
  endtask

  // Torque scaling, buzzer left on by an open loop, wrapped buzzer deadline
  task automatic test_directed_sequence();
    write_regs(16'd50, 16'd100, 15'h7FFF);
    go_buzzer();
    tick(101, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sh7FFF);
    tick(1, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sh8000);
    tick(1, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd16384);
    tick(1, 1, 0, 0, 0, CON_ACTIVE, INV_OTHER, 16'sd1);
    tick(1, 0, 0, 0, 0, CON_ACTIVE, INV_OTHER, 16'sd100);
    // loop opens mid-beep: buzzer level stays up
    go_buzzer();
    tick(1, 0, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd0);
    // buzzer deadline wraps past 2^32 and expires on the next tick
    clock_ms = 32'hFFFF_FFC0;
    go_buzzer();
    tick(1, 1, 0, 0, 0, CON_ACTIVE, INV_DRIVE, 16'sd12345);
    wait_quiet();
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_full_pipeline();
    long_hold = 1'b1;
    run_random(40);
    wait_quiet();
  endtask

  task automatic test_random_settings();
    write_regs(16'hFFFF, 16'hFFFF, 15'h7FFF);
    run_random(380);
    wait_quiet();
    write_regs(16'd0, 16'd0, 15'd0);
    run_random(380);
    wait_quiet();
    write_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), 15'($urandom));
    run_random(380);
    wait_quiet();
    idle_on = 1'b0;
    write_regs(16'($urandom), 16'($urandom), 15'($urandom));
    run_random(380);
    wait_quiet();
  endtask

  // Close timeout into error, then error must hold whatever comes in
  task automatic test_sticky_error();
    logic [63:0] bits;
    in_word_t    w;
    write_regs(16'd10, 16'd5, 15'd12345);
    tick(1, 0, 0, 0, 0, CON_OTHER, INV_OTHER, 16'sd0);
    tick(1, 1, 1, 0, 0, CON_READY, INV_OTHER, 16'sd0);
    tick(11, 1, 0, 0, 0, CON_OTHER, INV_OTHER, 16'sd0);
    tick(1, 1, 1, 1, 1, CON_ERROR, INV_DRIVE, 16'sh7FFF);
    tick(1, 0, 0, 0, 0, CON_READY, INV_DRIVE, 16'sd0);
    clock_ms = 32'hFFFF_FFFE;
    tick(1, 1, 1, 1, 1, CON_ACTIVE, INV_UNKNOWN, -16'sd1);
    tick(1, 1, 1, 1, 1, CON_ACTIVE, INV_DRIVE, 16'sd20000);
    repeat (40) begin
      bits = {$urandom, $urandom};
      w = bits[55:0];
      send_word(w);
    end
    wait_quiet();
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_sequence();
    test_full_pipeline();
    test_random_settings();
    test_sticky_error();
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      err_count++;
    end
    $display("Sent %0d words: reset values, directed sequence, back-pressure,", words_sent);
    $display("four register settings and the sticky error state; driving entered %0d times.",
             drive_entries);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
